FILE: src/jsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_STR,
		PH_ESC,
		PH_HEX
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_CLOSE = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_marker;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		kind_t      out_kind;
		logic       run_last;
	} out_item_t;

	// One input item's worth of results; cnt is 1 to 3 when queued.
	typedef struct packed {
		logic [1:0]      cnt;
		kind_t           kind;
		logic [2:0][7:0] bytes;
	} run_t;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_U = 8'h75;

	localparam logic [15:0] UTF8_MAX1 = 16'h007f;
	localparam logic [15:0] UTF8_MAX2 = 16'h07ff;
	localparam logic [7:0] UTF8_LEAD2 = 8'hc0;
	localparam logic [7:0] UTF8_LEAD3 = 8'he0;
	localparam logic [7:0] UTF8_CONT = 8'h80;

	// {ok, value}
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	// {ok, mapped byte}
	function automatic logic [8:0] esc_map(input logic [7:0] c);
		logic [8:0] r;
		r = '0;
		case (c)
			CH_QUOTE:  r = {1'b1, CH_QUOTE};
			CH_BSLASH: r = {1'b1, CH_BSLASH};
			CH_SLASH:  r = {1'b1, CH_SLASH};
			8'h62:     r = {1'b1, 8'h08};
			8'h66:     r = {1'b1, 8'h0c};
			8'h6e:     r = {1'b1, CH_LF};
			8'h72:     r = {1'b1, CH_CR};
			8'h74:     r = {1'b1, CH_TAB};
			default:   r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: src/jsu_front.sv
`timescale 1ns / 1ps
`default_nettype none

module jsu_front import jsu_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     src_valid,
	output logic          src_stall,
	input  wire in_item_t src_item,
	input  wire logic     full,
	output logic          push,
	output run_t          push_run
);

	phase_t      phase_q, phase_d;
	logic [1:0]  digits_q, digits_d;
	logic [15:0] cp_q, cp_d;

	logic        accept;
	logic [7:0]  c;
	logic [4:0]  hv;
	logic [8:0]  em;
	logic [15:0] cp_next;
	logic        is_ws;

	assign src_stall = full;
	assign accept = src_valid && !full;
	assign c = src_item.text_byte;
	assign hv = hex_value(c);
	assign em = esc_map(c);
	assign cp_next = {cp_q[11:0], hv[3:0]};
	assign is_ws = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);

	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			if (src_item.end_marker) begin
				phase_d = PH_IDLE;
			end else begin
				unique case (phase_q)
					PH_IDLE: begin
						if (c == CH_QUOTE) phase_d = PH_STR;
					end
					PH_STR: begin
						if (c == CH_QUOTE) phase_d = PH_IDLE;
						else if (c == CH_BSLASH) phase_d = PH_ESC;
					end
					PH_ESC: begin
						if (em[8]) phase_d = PH_STR;
						else if (c == CH_U) phase_d = PH_HEX;
						else phase_d = PH_IDLE;
					end
					PH_HEX: begin
						if (!hv[4]) phase_d = PH_IDLE;
						else if (digits_q == 2'd3) phase_d = PH_STR;
					end
					default: phase_d = PH_IDLE;
				endcase
			end
		end
	end

	always_comb begin
		digits_d = digits_q;
		cp_d = cp_q;
		push_run = '0;
		push_run.kind = KIND_BYTE;
		if (accept) begin
			if (phase_q == PH_HEX && !src_item.end_marker && hv[4] && digits_q != 2'd3) begin
				cp_d = cp_next;
				digits_d = digits_q + 2'd1;
			end else begin
				cp_d = '0;
				digits_d = '0;
			end
			if (src_item.end_marker) begin
				if (phase_q != PH_IDLE) begin
					push_run.cnt = 2'd1;
					push_run.kind = KIND_ERROR;
				end
			end else begin
				unique case (phase_q)
					PH_IDLE: begin
						if (c != CH_QUOTE && !is_ws) begin
							push_run.cnt = 2'd1;
							push_run.kind = KIND_ERROR;
						end
					end
					PH_STR: begin
						if (c == CH_QUOTE) begin
							push_run.cnt = 2'd1;
							push_run.kind = KIND_CLOSE;
						end else if (c != CH_BSLASH) begin
							push_run.cnt = 2'd1;
							push_run.bytes[0] = c;
						end
					end
					PH_ESC: begin
						if (em[8]) begin
							push_run.cnt = 2'd1;
							push_run.bytes[0] = em[7:0];
						end else if (c != CH_U) begin
							push_run.cnt = 2'd1;
							push_run.kind = KIND_ERROR;
						end
					end
					PH_HEX: begin
						if (!hv[4]) begin
							push_run.cnt = 2'd1;
							push_run.kind = KIND_ERROR;
						end else if (digits_q == 2'd3) begin
							if (cp_next <= UTF8_MAX1) begin
								push_run.cnt = 2'd1;
								push_run.bytes[0] = cp_next[7:0];
							end else if (cp_next <= UTF8_MAX2) begin
								push_run.cnt = 2'd2;
								push_run.bytes[0] = UTF8_LEAD2 | {3'b000, cp_next[10:6]};
								push_run.bytes[1] = UTF8_CONT | {2'b00, cp_next[5:0]};
							end else begin
								push_run.cnt = 2'd3;
								push_run.bytes[0] = UTF8_LEAD3 | {4'h0, cp_next[15:12]};
								push_run.bytes[1] = UTF8_CONT | {2'b00, cp_next[11:6]};
								push_run.bytes[2] = UTF8_CONT | {2'b00, cp_next[5:0]};
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign push = accept && (push_run.cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			digits_q <= '0;
			cp_q <= '0;
		end else begin
			phase_q <= phase_d;
			digits_q <= digits_d;
			cp_q <= cp_d;
		end
	end

endmodule

`default_nettype wire

FILE: src/jsu_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue import jsu_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire run_t push_run,
	output logic      full,
	output logic      head_valid,
	output run_t      head_run,
	input  wire logic pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	run_t             entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_run = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entries_q[wr_ptr_q] <= push_run;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: src/jsu_back.sv
`timescale 1ns / 1ps
`default_nettype none

module jsu_back import jsu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  wire run_t head_run,
	output logic      pop,
	output logic      dst_valid,
	input  wire logic dst_stall,
	output out_item_t dst_item
);

	logic [1:0] idx_q;
	logic       valid_q;
	out_item_t  item_q;
	logic       load;
	logic       last;

	assign load = !valid_q || !dst_stall;
	assign last = (idx_q == head_run.cnt - 2'd1);
	assign pop = load && head_valid && last;
	assign dst_valid = valid_q;
	assign dst_item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			valid_q <= head_valid;
			if (head_valid) idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			item_q.out_byte <= head_run.bytes[idx_q];
			item_q.out_kind <= head_run.kind;
			item_q.run_last <= last;
		end
	end

endmodule

`default_nettype wire

FILE: src/json_string_unescaper.sv
// JSON string unescaper: takes one text byte per item and emits decoded string
// bytes, a close marker per string, or an error marker. Input items are taken
// while the run queue (QUEUE_DEPTH entries) has room; each item's 1 to 3 results
// are queued as one run (items with none are not queued), and the output register
// sends one result per cycle while dst_stall is low, so items yielding at most one
// result sustain one per cycle and a \u escape yielding 2 or 3 UTF-8 bytes holds
// the output for its whole run. Runs pass through the queue to the output register.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescaper import jsu_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     src_valid,
	output logic          src_stall,
	input  wire in_item_t src_item,
	output logic          dst_valid,
	input  wire logic     dst_stall,
	output out_item_t     dst_item
);

	logic push, full, head_valid, pop;
	run_t push_run, head_run;

	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_item (src_item),
		.full     (full),
		.push     (push),
		.push_run (push_run)
	);

	jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_run  (push_run),
		.full      (full),
		.head_valid(head_valid),
		.head_run  (head_run),
		.pop       (pop)
	);

	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_run  (head_run),
		.pop       (pop),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_item  (dst_item)
	);

endmodule

`default_nettype wire

FILE: src/jsu_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module jsu_checker import jsu_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      src_valid,
	input wire logic      src_stall,
	input wire in_item_t  src_item,
	input wire logic      dst_valid,
	input wire logic      dst_stall,
	input wire out_item_t dst_item
);

	// stalled input item holds
	a_src_hold: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_stall |=> src_valid && $stable(src_item))
		else $error("stalled input item changed");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid && $stable(dst_item))
		else $error("stalled result changed");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid |-> dst_item.out_kind == KIND_BYTE || dst_item.out_kind == KIND_CLOSE
			|| dst_item.out_kind == KIND_ERROR)
		else $error("bad result kind");

	// close and error are single-result runs with a zero byte
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_item.out_kind != KIND_BYTE |-> dst_item.run_last
			&& dst_item.out_byte == 8'h00)
		else $error("marker result malformed");

	// a run is sent without gaps
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_stall && !dst_item.run_last |=> dst_valid
			&& dst_item.out_kind == KIND_BYTE)
		else $error("gap inside a run");

endmodule

bind json_string_unescaper jsu_checker u_chk (.*);

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import jsu_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 10;
	localparam int MAX_SHOWN = 10;

	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [7:0] CH_N = 8'h6e;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_X = 8'h78;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_UP_A = 8'h41;
	localparam logic [7:0] CH_UP_F = 8'h46;
	localparam logic [7:0] CH_LOW_F = 8'h66;
	localparam logic [7:0] CODE_BS = 8'h08;
	localparam logic [7:0] CODE_FF = 8'h0c;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_stall;
	in_item_t src_item = '0;
	logic dst_valid;
	logic dst_stall = 1'b0;
	out_item_t dst_item;

	phase_t ph = PH_IDLE;
	logic [1:0] hex_cnt = '0;
	logic [15:0] cp_acc = '0;
	out_item_t decoded_q[$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int cycles = 0;
	int n_items = 0;
	int n_results = 0;
	int n_closes = 0;
	int n_errors = 0;
	int n_multi = 0;
	int n_mismatch = 0;

	json_string_unescaper dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_item (src_item),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_item (dst_item)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				decoded_q.size());
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		dst_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
	end

	// ---- decoding predictor ----

	function automatic int nibble_of(input logic [7:0] c);
		if (c >= CH_0 && c <= CH_0 + 8'd9)
			return int'(c - CH_0);
		if (c >= CH_LOW_A && c <= CH_LOW_F)
			return int'(c - CH_LOW_A) + 10;
		if (c >= CH_UP_A && c <= CH_UP_F)
			return int'(c - CH_UP_A) + 10;
		return -1;
	endfunction

	function automatic int escape_value(input logic [7:0] c);
		case (c)
			CH_QUOTE:  return int'(CH_QUOTE);
			CH_BSLASH: return int'(CH_BSLASH);
			CH_SLASH:  return int'(CH_SLASH);
			CH_B:      return int'(CODE_BS);
			CH_F:      return int'(CODE_FF);
			CH_N:      return int'(CH_LF);
			CH_R:      return int'(CH_CR);
			CH_T:      return int'(CH_TAB);
			default:   return -1;
		endcase
	endfunction

	function automatic out_item_t mk_result(input logic [7:0] b, input kind_t k);
		out_item_t r;
		r.out_byte = b;
		r.out_kind = k;
		r.run_last = 1'b0;
		return r;
	endfunction

	task automatic go_idle();
		ph = PH_IDLE;
		hex_cnt = '0;
		cp_acc = '0;
	endtask

	task automatic unescape_step(input in_item_t it);
		out_item_t run[$];
		logic [7:0] c;
		logic [15:0] cp;
		int d;
		int m;
		c = it.text_byte;
		if (it.end_marker) begin
			if (ph != PH_IDLE)
				run.insert(run.size(), mk_result(8'h00, KIND_ERROR));
			go_idle();
		end else begin
			case (ph)
				PH_IDLE: begin
					if (c == CH_QUOTE) begin
						ph = PH_STR;
					end else if (!(c == CH_SPACE || c == CH_TAB || c == CH_CR
							|| c == CH_LF)) begin
						run.insert(run.size(), mk_result(8'h00, KIND_ERROR));
						go_idle();
					end
				end
				PH_STR: begin
					if (c == CH_QUOTE) begin
						run.insert(run.size(), mk_result(8'h00, KIND_CLOSE));
						go_idle();
					end else if (c == CH_BSLASH) begin
						ph = PH_ESC;
					end else begin
						run.insert(run.size(), mk_result(c, KIND_BYTE));
					end
				end
				PH_ESC: begin
					m = escape_value(c);
					if (m >= 0) begin
						run.insert(run.size(), mk_result(m[7:0], KIND_BYTE));
						ph = PH_STR;
					end else if (c == CH_U) begin
						ph = PH_HEX;
						hex_cnt = '0;
						cp_acc = '0;
					end else begin
						run.insert(run.size(), mk_result(8'h00, KIND_ERROR));
						go_idle();
					end
				end
				default: begin
					d = nibble_of(c);
					if (d < 0) begin
						run.insert(run.size(), mk_result(8'h00, KIND_ERROR));
						go_idle();
					end else begin
						cp = {cp_acc[11:0], d[3:0]};
						if (hex_cnt == 2'd3) begin
							if (cp <= UTF8_MAX1) begin
								run.insert(run.size(), mk_result(cp[7:0], KIND_BYTE));
							end else if (cp <= UTF8_MAX2) begin
								run.insert(run.size(),
									mk_result(UTF8_LEAD2 | {3'b000, cp[10:6]}, KIND_BYTE));
								run.insert(run.size(),
									mk_result(UTF8_CONT | {2'b00, cp[5:0]}, KIND_BYTE));
							end else begin
								run.insert(run.size(),
									mk_result(UTF8_LEAD3 | {4'h0, cp[15:12]}, KIND_BYTE));
								run.insert(run.size(),
									mk_result(UTF8_CONT | {2'b00, cp[11:6]}, KIND_BYTE));
								run.insert(run.size(),
									mk_result(UTF8_CONT | {2'b00, cp[5:0]}, KIND_BYTE));
							end
							ph = PH_STR;
							hex_cnt = '0;
							cp_acc = '0;
						end else begin
							cp_acc = cp;
							hex_cnt = hex_cnt + 2'd1;
						end
					end
				end
			endcase
		end
		if (run.size() > 1)
			n_multi++;
		if (run.size() > 0)
			run[run.size() - 1].run_last = 1'b1;
		foreach (run[i])
			decoded_q.insert(decoded_q.size(), run[i]);
	endtask

	// ---- result checking ----

	task automatic report_bad(input string what, input out_item_t want, input out_item_t got);
		n_mismatch++;
		if (n_mismatch <= MAX_SHOWN)
			$display("%0t %s: expected %02h/%0d/%0b, got %02h/%0d/%0b (byte/kind/last)",
				$realtime, what, want.out_byte, want.out_kind, want.run_last,
				got.out_byte, got.out_kind, got.run_last);
	endtask

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && dst_valid && !dst_stall) begin
			n_results++;
			if (dst_item.out_kind == KIND_CLOSE)
				n_closes++;
			if (dst_item.out_kind == KIND_ERROR)
				n_errors++;
			if (decoded_q.size() == 0) begin
				report_bad("unexpected result", '0, dst_item);
			end else begin
				want = decoded_q.pop_front();
				if (dst_item.out_byte !== want.out_byte || dst_item.out_kind !== want.out_kind
						|| dst_item.run_last !== want.run_last)
					report_bad("result mismatch", want, dst_item);
			end
		end
	end

	// ---- stimulus ----

	task automatic send_item(input logic [7:0] b, input logic e);
		in_item_t it;
		it.text_byte = b;
		it.end_marker = e;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_item <= it;
		do @(posedge clk); while (src_stall);
		unescape_step(it);
		n_items++;
	endtask

	task automatic wait_drained();
		src_valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
		if (nib < 4'd10)
			return CH_0 + {4'h0, nib};
		return (upper ? CH_UP_A : CH_LOW_A) + {4'h0, nib} - 8'd10;
	endfunction

	function automatic logic [7:0] space_byte();
		case ($urandom_range(3))
			0:       return CH_SPACE;
			1:       return CH_TAB;
			2:       return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	function automatic logic [7:0] escape_letter();
		case ($urandom_range(7))
			0:       return CH_QUOTE;
			1:       return CH_BSLASH;
			2:       return CH_SLASH;
			3:       return CH_B;
			4:       return CH_F;
			5:       return CH_N;
			6:       return CH_R;
			default: return CH_T;
		endcase
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (b == CH_QUOTE || b == CH_BSLASH);
		return b;
	endfunction

	function automatic logic [7:0] bad_escape_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (escape_value(b) >= 0 || b == CH_U);
		return b;
	endfunction

	function automatic logic [7:0] bad_hex_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (nibble_of(b) >= 0);
		return b;
	endfunction

	function automatic logic [15:0] random_code_point();
		case ($urandom_range(3))
			0: return 16'($urandom_range(16'h007f));
			1: return 16'($urandom_range(16'h07ff, 16'h0080));
			2: return 16'($urandom_range(16'hffff, 16'h0800));
			default: begin
				case ($urandom_range(7))
					0:       return 16'h0000;
					1:       return 16'h007f;
					2:       return 16'h0080;
					3:       return 16'h07ff;
					4:       return 16'h0800;
					5:       return 16'hd800;
					6:       return 16'hdfff;
					default: return 16'hffff;
				endcase
			end
		endcase
	endfunction

	task automatic send_unicode(input logic [15:0] cp);
		send_item(CH_BSLASH, 1'b0);
		send_item(CH_U, 1'b0);
		for (int i = 3; i >= 0; i--)
			send_item(hex_char(cp[i*4 +: 4], 1'($urandom_range(1))), 1'b0);
	endtask

	task automatic send_string_unit();
		int pick;
		pick = $urandom_range(9);
		if (pick < 6) begin
			send_item(plain_byte(), 1'b0);
		end else if (pick < 8) begin
			send_item(CH_BSLASH, 1'b0);
			send_item(escape_letter(), 1'b0);
		end else begin
			send_unicode(random_code_point());
		end
	endtask

	task automatic send_partial_hex();
		send_item(CH_BSLASH, 1'b0);
		send_item(CH_U, 1'b0);
		repeat ($urandom_range(3))
			send_item(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))), 1'b0);
	endtask

	task automatic send_good_string();
		repeat ($urandom_range(2))
			send_item(space_byte(), 1'b0);
		send_item(CH_QUOTE, 1'b0);
		repeat ($urandom_range(8))
			send_string_unit();
		if ($urandom_range(9) == 0)
			send_item(8'($urandom_range(255)), 1'b1);
		else
			send_item(CH_QUOTE, 1'b0);
	endtask

	task automatic send_broken_string();
		send_item(CH_QUOTE, 1'b0);
		repeat ($urandom_range(3))
			send_string_unit();
		case ($urandom_range(3))
			0: begin
				send_item(CH_BSLASH, 1'b0);
				send_item(bad_escape_byte(), 1'b0);
			end
			1: begin
				send_partial_hex();
				send_item(bad_hex_byte(), 1'b0);
			end
			2: send_item(8'($urandom_range(255)), 1'b1);
			default: begin
				if ($urandom_range(1))
					send_partial_hex();
				else
					send_item(CH_BSLASH, 1'b0);
				send_item(8'($urandom_range(255)), 1'b1);
			end
		endcase
	endtask

	task automatic send_noise();
		repeat ($urandom_range(6, 1))
			send_item(8'($urandom_range(255)), $urandom_range(4) == 0);
	endtask

	// ---- tests ----

	task automatic test_idle_bytes();
		send_item(8'hff, 1'b1);
		send_item(CH_SPACE, 1'b0);
		send_item(CH_TAB, 1'b0);
		send_item(CH_CR, 1'b0);
		send_item(CH_LF, 1'b0);
		send_item(CH_X, 1'b0);
	endtask

	task automatic test_escapes();
		send_item(CH_QUOTE, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hff, 1'b0);
		send_item(CH_BSLASH, 1'b0); send_item(CH_QUOTE, 1'b0);
		send_item(CH_BSLASH, 1'b0); send_item(CH_BSLASH, 1'b0);
		send_item(CH_BSLASH, 1'b0); send_item(CH_SLASH, 1'b0);
		send_item(CH_BSLASH, 1'b0); send_item(CH_B, 1'b0);
		send_item(CH_BSLASH, 1'b0); send_item(CH_F, 1'b0);
		send_item(CH_BSLASH, 1'b0); send_item(CH_N, 1'b0);
		send_item(CH_BSLASH, 1'b0); send_item(CH_R, 1'b0);
		send_item(CH_BSLASH, 1'b0); send_item(CH_T, 1'b0);
		// mixed-case hex, top code point
		send_item(CH_BSLASH, 1'b0);
		send_item(CH_U, 1'b0);
		send_item(CH_UP_F, 1'b0);
		send_item(CH_LOW_F, 1'b0);
		send_item(CH_UP_F, 1'b0);
		send_item(CH_LOW_F, 1'b0);
		send_item(CH_QUOTE, 1'b0);
	endtask

	task automatic test_bad_sequences();
		send_item(CH_QUOTE, 1'b0);
		send_item(CH_BSLASH, 1'b0);
		send_item(CH_X, 1'b0);
		send_item(CH_QUOTE, 1'b0);
		send_item(CH_BSLASH, 1'b0);
		send_item(CH_U, 1'b0);
		send_item(CH_X, 1'b0);
		send_item(CH_QUOTE, 1'b0);
		send_item(8'h00, 1'b1);
	endtask

	task automatic test_random_text(input int count, input int idle_pct, input int hold_pct);
		int start;
		send_idle_pct = idle_pct;
		stall_pct = hold_pct;
		start = n_items;
		while (n_items - start < count) begin
			case ($urandom_range(19))
				0, 1, 2:  send_broken_string();
				3:        send_noise();
				default:  send_good_string();
			endcase
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_bytes();
		test_escapes();
		test_bad_sequences();
		// sender holds off until every expected result has come out
		wait_drained();
		test_random_text(65, 0, 0);
		test_random_text(65, 80, 0);
		test_random_text(65, 0, 80);
		test_random_text(65, 26, 26);
		wait_drained();
		$display("sent %0d text items under four idling mixes; checked %0d results", n_items,
			n_results);
		$display("  %0d string closes, %0d parse errors, %0d multi-byte UTF-8 runs", n_closes,
			n_errors, n_multi);
		if (n_mismatch == 0 && decoded_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches, %0d results missing", n_mismatch, decoded_q.size());
			$display("FAIL");
		end
		$finish;
	end

endmodule
